// File: hw/rtl/pll_pkg.sv
// pll_pkg: shared types and codes for the pooled linked list engine
// no dependencies
package pll_pkg;

	typedef enum logic [2:0] {
		FN_INS_HEAD  = 3'd0,
		FN_INS_AFTER = 3'd1,
		FN_DEL_HEAD  = 3'd2,
		FN_DEL_AFTER = 3'd3,
		FN_READ      = 3'd4,
		FN_WRITE     = 3'd5,
		FN_QUERY     = 3'd6,
		FN_SWAP      = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,      // waiting for a request
		S_RD1,       // link of cursor and value of cursor read
		S_RD2,       // second link read (successor)
		S_EXEC,      // decide and write
		S_SW_INIT,   // free-list chaining pass after reset
		S_SW_GATH,   // swap: gather values
		S_SW_PUT,    // swap: rewrite values
		S_OUT        // result waiting
	} state_t;

	localparam int unsigned POOL_NODES  = 64;
	localparam int unsigned ANCHOR_NODE = 0;
	localparam int unsigned LINK_END    = 0;

	// request word {func, cursor, value}
	typedef struct packed {
		func_t              func;
		logic [5:0]         cursor;
		logic signed [31:0] value;
	} req_word_t;

	// result word
	typedef struct packed {
		logic signed [31:0] read_value;
		logic [5:0]         link_index;
		logic [5:0]         new_node;
		logic [5:0]         list_size;
		logic               is_empty;
		status_t            status;
	} rsp_word_t;

	// controller to datapath
	typedef struct packed {
		logic load_req;    // capture request word
		logic rd_cur;      // read link/value at cursor
		logic rd_succ;     // read link of the cursor's successor
		logic exec;        // perform the list update and build the result
		logic init_step;   // one entry of the post-reset link chain
		logic sw_start;    // begin swap walk
		logic sw_gath;     // one gather step
		logic sw_put;      // one rewrite step
	} pll_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic init_last;
		logic sw_skip;     // fewer than two elements
		logic sw_gath_last;
		logic sw_put_last;
		logic is_swap;
	} pll_sts_t;

endpackage

// File: hw/rtl/pll_if.sv
// pll_if: valid/ready channel carrying one payload word
// depends on nothing
interface pll_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/pll_ctrl.sv
// pll_ctrl: sequencer for the pooled linked list engine
// depends on pll_pkg
module pll_ctrl
	import pll_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  pll_sts_t sts,
	output pll_cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_SW_INIT;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_SW_INIT: if (sts.init_last) state_d = S_IDLE;
			S_IDLE: if (in_valid) state_d = S_RD1;
			S_RD1: begin
				if (sts.is_swap) state_d = sts.sw_skip ? S_OUT : S_SW_GATH;
				else state_d = S_RD2;
			end
			S_RD2: state_d = S_EXEC;
			S_EXEC: state_d = S_OUT;
			S_SW_GATH: if (sts.sw_gath_last) state_d = S_SW_PUT;
			S_SW_PUT: if (sts.sw_put_last) state_d = S_OUT;
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_SW_INIT: cmd.init_step = 1'b1;
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
			end
			S_RD1: begin
				cmd.rd_cur   = 1'b1;
				cmd.sw_start = sts.is_swap;
			end
			S_RD2: cmd.rd_succ = 1'b1;
			S_EXEC: cmd.exec = 1'b1;
			S_SW_GATH: cmd.sw_gath = 1'b1;
			S_SW_PUT: cmd.sw_put = 1'b1;
			S_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

// File: hw/rtl/pll_dp.sv
// pll_dp: link/value memories, free list and swap scratch
// depends on pll_pkg
module pll_dp
	import pll_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pll_cmd_t           cmd,
	output pll_sts_t           sts,
	input  logic [2:0]         req_func,
	input  logic [5:0]         req_cursor,
	input  logic signed [31:0] req_value,
	output logic signed [31:0] read_value,
	output logic [5:0]         link_index,
	output logic [5:0]         new_node,
	output logic [5:0]         list_size,
	output logic               is_empty,
	output status_t            status
);
	localparam int unsigned IW = $clog2(POOL_NODES);

	logic [IW-1:0]         link_mem [POOL_NODES];
	logic [VALUE_BITS-1:0] val_mem  [POOL_NODES];
	logic [VALUE_BITS-1:0] scr_mem  [POOL_NODES];

	func_t                 func_q;
	logic [IW-1:0]         cur_q;
	logic                  term_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [IW-1:0]         free_q;
	logic [IW:0]           count_q;
	logic [IW-1:0]         head_q;     // mirror of link_mem[0]
	logic [IW-1:0]         clink_q;    // link of cursor
	logic [IW-1:0]         slink_q;    // link of cursor's successor
	logic [IW-1:0]         flink_q;    // link of free head
	logic [VALUE_BITS-1:0] cval_q;
	logic [IW-1:0]         init_q;

	// swap walk
	logic [IW:0]           sw_i_q;
	logic [IW-1:0]         sw_node_q;
	logic [IW:0]           sw_n_q;
	logic                  sw_stop;
	logic [IW:0]           sw_mid, sw_src;

	// swap memory traffic, one register between read and write
	logic [VALUE_BITS-1:0] gval_q, pval_q;
	logic [IW-1:0]         gidx_q, pnode_q;
	logic                  gwe_q, pwe_q;

	// memory ports: a link read, two link writes and a value write
	logic [IW-1:0] ra;
	logic [IW-1:0] lrd;
	logic          lwe;
	logic [IW-1:0] lwa, lwd;
	logic          lwe2;
	logic [IW-1:0] lwa2, lwd2;
	logic          vwe;
	logic [IW-1:0] vwa;
	logic [VALUE_BITS-1:0] vwd;

	// result regs
	logic [31:0]   rd_q;
	logic [IW-1:0] lk_q, nn_q;
	status_t       st_q;

	logic [IW:0] cur_ext;
	assign cur_ext = {1'b0, req_cursor[IW-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			func_q <= func_t'(req_func);
			cur_q  <= (req_func == FN_INS_HEAD || req_func == FN_DEL_HEAD)
				? IW'(ANCHOR_NODE) : req_cursor[IW-1:0];
			term_q <= (req_cursor == 6'(ANCHOR_NODE)) ||
				(32'(req_cursor) >= 32'(POOL_NODES)) || (cur_ext != 7'(req_cursor));
			val_q  <= VALUE_BITS'(64'(signed'(req_value)));
		end
	end

	// read address: cursor in RD1, successor in RD2 via clink
	assign ra  = cmd.rd_cur ? cur_q : clink_q;
	assign lrd = link_mem[ra];

	always_ff @(posedge clk) begin
		if (cmd.rd_cur) begin
			clink_q <= lrd;
			cval_q  <= val_mem[cur_q];
			flink_q <= link_mem[free_q];
		end
		if (cmd.rd_succ) slink_q <= lrd;
	end

	logic full, del_ok;
	assign full   = (free_q == IW'(LINK_END)) || (count_q >= (IW+1)'(POOL_NODES - 1));
	assign del_ok = (count_q != '0) && (clink_q != IW'(ANCHOR_NODE));

	always_comb begin
		lwe = 1'b0; lwa = '0; lwd = '0;
		lwe2 = 1'b0; lwa2 = '0; lwd2 = '0;
		vwe = 1'b0; vwa = '0; vwd = '0;
		if (cmd.init_step) begin
			lwe = 1'b1; lwa = init_q;
			lwd = (init_q == '0 || init_q == IW'(POOL_NODES - 1)) ? '0 : init_q + 1'b1;
		end else if (cmd.exec) begin
			unique case (func_q)
				FN_INS_HEAD, FN_INS_AFTER: if (!(func_q == FN_INS_AFTER && term_q) && !full) begin
					lwe = 1'b1; lwa = free_q; lwd = (free_q == cur_q) ? free_q : clink_q;
					lwe2 = 1'b1; lwa2 = cur_q; lwd2 = free_q;
					vwe = 1'b1; vwa = free_q; vwd = val_q;
				end
				FN_DEL_HEAD, FN_DEL_AFTER: if (!(func_q == FN_DEL_AFTER && term_q) && del_ok) begin
					lwe = 1'b1; lwa = cur_q; lwd = slink_q;
					lwe2 = 1'b1; lwa2 = clink_q; lwd2 = free_q;
				end
				FN_WRITE: if (!term_q) begin
					vwe = 1'b1; vwa = cur_q; vwd = val_q;
				end
				default: ;
			endcase
		end else if (pwe_q) begin
			vwe = 1'b1; vwa = pnode_q; vwd = pval_q;
		end
	end

	// second write wins on the same address, as in the model's order
	always_ff @(posedge clk) begin
		if (lwe) link_mem[lwa] <= lwd;
		if (lwe2) link_mem[lwa2] <= lwd2;
		if (vwe) val_mem[vwa] <= vwd;
		if (gwe_q) scr_mem[gidx_q] <= gval_q;
	end

	// head mirror tracks writes to node 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0; free_q <= IW'(1); count_q <= '0; init_q <= '0;
		end else begin
			if (cmd.init_step) init_q <= init_q + 1'b1;
			if (lwe2 && lwa2 == '0) head_q <= lwd2;
			else if (lwe && lwa == '0) head_q <= lwd;
			if (cmd.exec) begin
				if ((func_q == FN_INS_HEAD || (func_q == FN_INS_AFTER && !term_q)) && !full) begin
					free_q  <= flink_q;
					count_q <= count_q + 1'b1;
				end
				if ((func_q == FN_DEL_HEAD || (func_q == FN_DEL_AFTER && !term_q)) && del_ok) begin
					free_q  <= clink_q;
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	// swap walk
	assign sw_mid  = sw_n_q >> 1;
	assign sw_stop = (sw_node_q == '0) || (sw_i_q >= count_q);
	always_comb begin
		// destination i takes source: upper half, then middle, then lower half
		if (sw_i_q < sw_n_q - sw_mid - (sw_n_q[0] ? 1'b1 : 1'b0))
			sw_src = sw_i_q + sw_mid + (sw_n_q[0] ? 1'b1 : 1'b0);
		else if (sw_n_q[0] && sw_i_q == sw_mid)
			sw_src = sw_mid;
		else
			sw_src = sw_i_q - (sw_n_q - sw_mid);
	end

	always_ff @(posedge clk) begin
		if (cmd.sw_start) begin
			sw_i_q <= '0; sw_node_q <= head_q;
		end else if (cmd.sw_gath) begin
			if (sw_stop) begin
				sw_n_q <= sw_i_q; sw_i_q <= '0; sw_node_q <= head_q;
			end else begin
				sw_i_q <= sw_i_q + 1'b1; sw_node_q <= link_mem[sw_node_q];
			end
		end else if (cmd.sw_put) begin
			sw_i_q <= sw_i_q + 1'b1; sw_node_q <= link_mem[sw_node_q];
		end
	end

	// read data lands in a register, the memory write follows in the next cycle
	always_ff @(posedge clk) begin
		if (cmd.sw_gath) begin
			gval_q <= val_mem[sw_node_q];
			gidx_q <= sw_i_q[IW-1:0];
		end
		if (cmd.sw_put) begin
			pval_q  <= scr_mem[sw_src[IW-1:0]];
			pnode_q <= sw_node_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gwe_q <= 1'b0;
			pwe_q <= 1'b0;
		end else begin
			gwe_q <= cmd.sw_gath && !sw_stop;
			pwe_q <= cmd.sw_put && !sw_stop;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			rd_q <= '0; lk_q <= '0; nn_q <= '0; st_q <= ST_DONE;
		end else if (cmd.exec) begin
			unique case (func_q)
				FN_INS_HEAD, FN_INS_AFTER:
					if (func_q == FN_INS_AFTER && term_q) st_q <= ST_IGNORED;
					else if (full) st_q <= ST_FULL;
					else nn_q <= free_q;
				FN_DEL_HEAD, FN_DEL_AFTER:
					if ((func_q == FN_DEL_AFTER && term_q) || !del_ok) st_q <= ST_IGNORED;
				FN_READ:
					if (term_q) st_q <= ST_IGNORED;
					else begin
						rd_q <= 32'(cval_q);
						lk_q <= clink_q;
					end
				FN_WRITE: if (term_q) st_q <= ST_IGNORED;
				FN_QUERY: lk_q <= head_q;
				default: ;
			endcase
		end
	end

	assign sts.init_last    = (init_q == IW'(POOL_NODES - 1));
	assign sts.is_swap      = (func_q == FN_SWAP);
	assign sts.sw_skip      = (count_q < 2);
	assign sts.sw_gath_last = cmd.sw_gath && sw_stop;
	assign sts.sw_put_last  = cmd.sw_put && (sw_stop || sw_i_q + 1'b1 >= sw_n_q);

	assign read_value = rd_q;
	assign link_index = 6'(lk_q);
	assign new_node   = 6'(nn_q);
	assign list_size  = 6'(count_q);
	assign is_empty   = (count_q == '0);
	assign status     = st_q;
endmodule

// File: hw/rtl/pooled_linked_list_engine.sv
// pooled_linked_list_engine: top level, sequencer plus list datapath
// depends on pll_pkg, pll_if, pll_ctrl, pll_dp
//
// usage:
// - req channel carries one word {func, cursor, value}; rsp channel returns
//   one word per request with read_value, link_index, new_node, list_size,
//   is_empty and status
// - one request at a time: accept, read cursor link and value, read the
//   successor link, update, then present the result
// - swap over n elements: two passes over the list, a gather pass and a
//   rewrite pass; with fewer than two elements the result is presented
//   without either pass
// - after reset the link memory is chained into a free list, one node per
//   cycle, with req.ready low until the whole pool is chained
// - the result sits in the output register until rsp.ready; no new request
//   is taken until it has gone
// - value memory is not cleared; reading a node never written is undefined
module pooled_linked_list_engine
	import pll_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	pll_if.sink   req,
	pll_if.source rsp
);
	pll_cmd_t cmd;
	pll_sts_t sts;
	logic out_valid;

	// controller owns the handshake
	pll_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid (req.valid), .in_ready (req.ready),
		.out_valid(out_valid), .out_ready(rsp.ready),
		.sts, .cmd
	);
	assign rsp.valid = out_valid;

	// request word unpacks as func, cursor, value
	pll_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.req_func  (req.data.func),
		.req_cursor(req.data.cursor),
		.req_value (req.data.value),
		.read_value(rsp.data.read_value),
		.link_index(rsp.data.link_index),
		.new_node  (rsp.data.new_node),
		.list_size (rsp.data.list_size),
		.is_empty  (rsp.data.is_empty),
		.status    (rsp.data.status)
	);

	// never both ready and valid at once: one request in flight
	assert property (@(posedge clk) disable iff (!arst_n) !(req.ready && rsp.valid))
		else $error("request taken while result pending");
	// a taken request gives no result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !rsp.valid)
		else $error("result too early");
	// is_empty agrees with the size
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.data.is_empty == (rsp.data.list_size == 6'd0)))
		else $error("empty flag mismatch");
endmodule

// File: bench/tb_pooled_linked_list_engine.sv
// tb_pooled_linked_list_engine: self-checking bench for the pooled linked list engine
// depends on pll_pkg, pll_if and pooled_linked_list_engine
`timescale 1ns / 100ps

module tb_pooled_linked_list_engine
	import pll_pkg::*;
();

	localparam int NODES = POOL_NODES;

	logic clk;
	logic arst_n;

	pll_if #(.T(req_word_t)) req ();
	pll_if #(.T(rsp_word_t)) rsp ();

	pooled_linked_list_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// shadow of the list memory, free list and element count
	logic [5:0]  shadow_link [NODES];
	logic [31:0] shadow_value [NODES];
	bit          shadow_written [NODES];
	logic [5:0]  shadow_free;
	int          shadow_count;

	req_word_t pending_words [$];
	rsp_word_t expected_results [$];
	int        error_count;
	int        cycle_count;
	bit        quiet;
	bit        req_taken;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// no idling on either side in this window of cycles
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end
	assign quiet = (cycle_count >= 4000) && (cycle_count < 9000);

	// true when a swap walk only touches nodes whose value has been set
	function automatic bit swap_reads_known();
		logic [5:0] node;
		int n;
		node = shadow_link[0];
		n = 0;
		while (node != 0 && n < shadow_count && n < NODES) begin
			if (!shadow_written[node])
				return 1'b0;
			n++;
			node = shadow_link[node];
		end
		return 1'b1;
	endfunction

	// rotate the list contents: back half first, middle kept in place on odd counts
	function automatic void swap_list_halves();
		logic [31:0] gathered [NODES];
		logic [31:0] reordered [NODES];
		logic [5:0] node;
		int n, k, mid, i;
		if (shadow_count < 2)
			return;
		n = 0;
		node = shadow_link[0];
		while (node != 0 && n < shadow_count && n < NODES) begin
			gathered[n] = shadow_value[node];
			n++;
			node = shadow_link[node];
		end
		mid = n / 2;
		k = 0;
		for (i = (n % 2 == 0) ? mid : mid + 1; i < n; i++)
			reordered[k++] = gathered[i];
		if (n % 2 != 0)
			reordered[k++] = gathered[mid];
		for (i = 0; i < mid; i++)
			reordered[k++] = gathered[i];
		node = shadow_link[0];
		for (i = 0; i < n && node != 0; i++) begin
			shadow_value[node] = reordered[i];
			node = shadow_link[node];
		end
	endfunction

	// apply one request to the shadow and return the result it must give
	function automatic rsp_word_t list_result(input req_word_t w);
		rsp_word_t r;
		logic [5:0] anchor, node, victim;
		bit on_term;
		r = '0;
		r.status = ST_DONE;
		on_term = (w.cursor == ANCHOR_NODE);
		case (w.func)
			FN_INS_HEAD, FN_INS_AFTER: begin
				anchor = (w.func == FN_INS_HEAD) ? 6'(ANCHOR_NODE) : w.cursor;
				if (w.func == FN_INS_AFTER && on_term) begin
					r.status = ST_IGNORED;
				end else if (shadow_free == LINK_END || shadow_count >= NODES - 1) begin
					r.status = ST_FULL;
				end else begin
					node = shadow_free;
					shadow_free = shadow_link[node];
					shadow_value[node] = w.value;
					shadow_written[node] = 1'b1;
					shadow_link[node] = shadow_link[anchor];
					shadow_link[anchor] = node;
					shadow_count++;
					r.new_node = node;
				end
			end
			FN_DEL_HEAD, FN_DEL_AFTER: begin
				anchor = (w.func == FN_DEL_HEAD) ? 6'(ANCHOR_NODE) : w.cursor;
				victim = shadow_link[anchor];
				if (w.func == FN_DEL_AFTER && on_term) begin
					r.status = ST_IGNORED;
				end else if (shadow_count == 0 || victim == ANCHOR_NODE) begin
					r.status = ST_IGNORED;
				end else begin
					shadow_link[anchor] = shadow_link[victim];
					shadow_link[victim] = shadow_free;
					shadow_free = victim;
					shadow_count--;
				end
			end
			FN_READ: begin
				if (on_term) begin
					r.status = ST_IGNORED;
				end else begin
					r.read_value = shadow_value[w.cursor];
					r.link_index = shadow_link[w.cursor];
				end
			end
			FN_WRITE: begin
				if (on_term) begin
					r.status = ST_IGNORED;
				end else begin
					shadow_value[w.cursor] = w.value;
					shadow_written[w.cursor] = 1'b1;
				end
			end
			FN_QUERY: r.link_index = shadow_link[0];
			default: swap_list_halves();
		endcase
		r.list_size = 6'(shadow_count);
		r.is_empty = (shadow_count == 0);
		return r;
	endfunction

	// queue a request; the block serves words strictly in order, so the
	// expected result is worked out here as the word is queued
	task automatic queue_request(input func_t f, input logic [5:0] cur, input logic [31:0] v);
		req_word_t w;
		w.func = f;
		w.cursor = cur;
		w.value = v;
		// never read a value that was never set
		if (w.func == FN_READ && !shadow_written[w.cursor])
			w.cursor = ANCHOR_NODE;
		if (w.func == FN_SWAP && !swap_reads_known())
			w.func = FN_QUERY;
		expected_results.push_back(list_result(w));
		pending_words.push_back(w);
	endtask

	// mostly a node on the list (or the terminator), sometimes any node
	function automatic logic [5:0] pick_cursor();
		logic [5:0] node;
		int hops;
		if ($urandom_range(99) < 25)
			return 6'($urandom_range(NODES - 1));
		hops = $urandom_range(shadow_count);
		node = ANCHOR_NODE;
		repeat (hops)
			node = shadow_link[node];
		return node;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return '0;
			default: return $urandom();
		endcase
	endfunction

	// driver: new word or idle at the falling edge once the last one was taken
	always @(posedge clk) begin
		req_taken <= req.valid && req.ready;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!req.valid || req_taken) begin
				if (pending_words.size() != 0 && (quiet || $urandom_range(99) >= 24)) begin
					req.valid <= 1'b1;
					req.data <= pending_words.pop_front();
				end else begin
					req.valid <= 1'b0;
				end
			end
			rsp.ready <= quiet || $urandom_range(99) >= 24;
		end
	end

	// monitor: compare each result word with the oldest expectation
	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected");
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (rsp.data.read_value !== want.read_value) begin
					$error("read_value expected %0d actual %0d", want.read_value,
						rsp.data.read_value);
					error_count++;
				end
				if (rsp.data.link_index !== want.link_index) begin
					$error("link_index expected %0d actual %0d", want.link_index,
						rsp.data.link_index);
					error_count++;
				end
				if (rsp.data.new_node !== want.new_node) begin
					$error("new_node expected %0d actual %0d", want.new_node,
						rsp.data.new_node);
					error_count++;
				end
				if (rsp.data.list_size !== want.list_size) begin
					$error("list_size expected %0d actual %0d", want.list_size,
						rsp.data.list_size);
					error_count++;
				end
				if (rsp.data.is_empty !== want.is_empty) begin
					$error("is_empty expected %0d actual %0d", want.is_empty,
						rsp.data.is_empty);
					error_count++;
				end
				if (rsp.data.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, rsp.data.status);
					error_count++;
				end
			end
		end
	end

	// stimulus: directed corner cases, then fill / drain / mixed phases
	initial begin
		int i, phase, pick;
		func_t f;
		error_count = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		shadow_link[0] = ANCHOR_NODE;
		for (i = 1; i < NODES - 1; i++)
			shadow_link[i] = 6'(i + 1);
		shadow_link[NODES - 1] = LINK_END;
		for (i = 0; i < NODES; i++) begin
			shadow_value[i] = '0;
			shadow_written[i] = 1'b0;
		end
		shadow_free = 6'd1;
		shadow_count = 0;

		// empty list: deletes and swap have nothing to do
		queue_request(FN_DEL_HEAD, 6'd0, '0);
		queue_request(FN_DEL_AFTER, 6'd1, '0);
		queue_request(FN_SWAP, 6'd0, '0);
		queue_request(FN_QUERY, 6'd0, '0);
		queue_request(FN_INS_HEAD, 6'd0, 32'h8000_0000);
		queue_request(FN_SWAP, 6'd0, '0);
		queue_request(FN_INS_HEAD, 6'd63, 32'h7fff_ffff);
		queue_request(FN_INS_AFTER, 6'd1, 32'hffff_ffff);
		queue_request(FN_SWAP, 6'd0, '0);
		queue_request(FN_INS_AFTER, 6'd0, 32'h1234_5678);
		queue_request(FN_READ, 6'd1, '0);
		queue_request(FN_READ, 6'd0, '0);
		queue_request(FN_WRITE, 6'd0, 32'h5555_5555);
		queue_request(FN_WRITE, 6'd2, 32'haaaa_aaaa);
		queue_request(FN_INS_AFTER, 6'd3, 32'd0);
		queue_request(FN_SWAP, 6'd0, '0);
		queue_request(FN_READ, 6'd2, '0);
		queue_request(FN_DEL_AFTER, 6'd0, '0);
		queue_request(FN_DEL_AFTER, 6'd1, '0);
		queue_request(FN_QUERY, 6'd0, '0);
		queue_request(FN_DEL_HEAD, 6'd0, '0);
		queue_request(FN_DEL_HEAD, 6'd0, '0);

		// phases of 150 words: fill to full, drain to empty, or mixed
		for (i = 0; i < 1830; i++) begin
			phase = (i / 150) % 3;
			pick = $urandom_range(99);
			if (phase == 0)
				f = (pick < 65) ? func_t'($urandom_range(1)) : func_t'($urandom_range(7));
			else if (phase == 1)
				f = (pick < 60) ? func_t'($urandom_range(3, 2)) : func_t'($urandom_range(7));
			else
				f = func_t'($urandom_range(7));
			queue_request(f, pick_cursor(), pick_value());
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_words.size() == 0 && expected_results.size() == 0);
		repeat (200) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: pooled_linked_list_engine.f
hw/rtl/pll_pkg.sv
hw/rtl/pll_if.sv
hw/rtl/pll_ctrl.sv
hw/rtl/pll_dp.sv
hw/rtl/pooled_linked_list_engine.sv
bench/tb_pooled_linked_list_engine.sv
